[src/lsru_pkg.sv]
// Shared types, operation codes and width helpers for the logic/shift/rotate unit.
// No dependencies; used by logic_shift_rotate_unit_core.
`default_nettype none

package lsru_pkg;

  // Operation kinds.
  localparam logic [3:0] KIND_AND = 4'd0;
  localparam logic [3:0] KIND_OR  = 4'd1;
  localparam logic [3:0] KIND_XOR = 4'd2;
  localparam logic [3:0] KIND_NOT = 4'd3;
  localparam logic [3:0] KIND_SHL = 4'd4;
  localparam logic [3:0] KIND_SHR = 4'd5;
  localparam logic [3:0] KIND_ROL = 4'd6;
  localparam logic [3:0] KIND_ROR = 4'd7;
  localparam logic [3:0] KIND_RCL = 4'd8;
  localparam logic [3:0] KIND_RCR = 4'd9;

  // BCD width codes.
  localparam logic [7:0] WCODE_8  = 8'h08;
  localparam logic [7:0] WCODE_16 = 8'h16;
  localparam logic [7:0] WCODE_32 = 8'h32;
  localparam logic [7:0] WCODE_64 = 8'h64;

  // Decoded width selector.
  typedef logic [1:0] wsel_t;
  localparam wsel_t WSEL_8  = 2'd0;
  localparam wsel_t WSEL_16 = 2'd1;
  localparam wsel_t WSEL_32 = 2'd2;
  localparam wsel_t WSEL_64 = 2'd3;

  function automatic logic [6:0] width_bits(input wsel_t sel);
    logic [6:0] bits;
    unique case (sel)
      WSEL_8:  bits = 7'd8;
      WSEL_16: bits = 7'd16;
      WSEL_32: bits = 7'd32;
      default: bits = 7'd64;
    endcase
    return bits;
  endfunction

  function automatic logic [63:0] width_mask(input wsel_t sel);
    logic [63:0] m;
    unique case (sel)
      WSEL_8:  m = 64'h0000_0000_0000_00FF;
      WSEL_16: m = 64'h0000_0000_0000_FFFF;
      WSEL_32: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[src/logic_shift_rotate_unit_core.sv]
// Top level of the logic/shift/rotate unit: input register, single-pass datapath
// and result register. Depends on lsru_pkg for operation codes and width helpers.
`default_nettype none

// Usage:
// An operation is transferred in at a rising edge where start is high and busy
// is low. busy is always low: the unit takes a new operation every cycle.
// The operation is captured in an input register; the next cycle the bitwise,
// shift and rotate logic evaluates it and the result register loads. The
// result appears on the out_ ports with out_strobe high for exactly one cycle
// once the result register has loaded. Throughput is one operation per clock,
// set by the single combinational pass between the two registers.
// The receiver cannot hold results off, so no back-pressure exists and no
// result is ever dropped: each transfer in yields exactly one transfer out.
// Reset (synchronous, active low) clears the valid flags of both registers;
// payload registers are not reset.
// Bitwise ops and shifts work on the full 64-bit operands (a shift count of
// 64 or more gives zero) and are truncated to the selected width (to DATA_WIDTH
// if that width is not legal). Rotates work within the selected width with the
// count modulo the width; rotate through carry uses a (width+1)-bit ring of the
// value and the carry flag. A rotate with an unknown width code, or a width
// above DATA_WIDTH, returns zero with illegal set. Unused kind codes return zero.
module logic_shift_rotate_unit_core #(
  parameter int DATA_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_kind,
  input  wire logic [7:0]  in_width_code,
  input  wire logic [63:0] in_operand_a,
  input  wire logic [63:0] in_operand_b,
  input  wire logic        in_carry_in,
  output logic             out_strobe,
  output logic [63:0]      out_result,
  output logic             out_carry_out,
  output logic             out_illegal
);

  // Final truncation to the datapath width.
  localparam logic [63:0] DW_MASK = (DATA_WIDTH >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                    ((64'd1 << DATA_WIDTH) - 64'd1);
  localparam logic [6:0]  DW_BITS = 7'(DATA_WIDTH);

  // Input register.
  logic        in_valid_r;
  logic [3:0]  kind_r;
  logic [7:0]  code_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic        cin_r;

  // Result register.
  logic        out_strobe_r;
  logic [63:0] result_r;
  logic        carry_r;
  logic        illegal_r;
  logic [63:0] result_nxt;
  logic        carry_nxt;
  logic        illegal_nxt;

  // Datapath signals.
  lsru_pkg::wsel_t wsel;
  logic            code_known;
  logic            legal_w;
  logic [63:0]     wmask;
  logic [63:0]     trunc_mask;
  logic            shift_sat;
  logic [5:0]      rot_mask;
  logic [5:0]      rot_n;
  logic [63:0]     rep;
  logic [127:0]    rep2;
  logic [127:0]    rol_full;
  logic [127:0]    ror_full;
  logic [64:0]     ring;
  logic [64:0]     ring_mask;
  logic [129:0]    ring_dbl;
  logic [191:0]    ring_lsh;
  logic [129:0]    ring_rsh;
  logic [64:0]     rcl_ring;
  logic [64:0]     rcr_ring;
  logic [64:0]     rc_ring;
  logic            rc_carry;
  logic [63:0]     logic_res;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start;
    end
    if (start) begin
      kind_r <= in_kind;
      code_r <= in_width_code;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      cin_r  <= in_carry_in;
    end
  end

  // Width decode. An unknown code, or one wider than the datapath, is not legal.
  always_comb begin
    code_known = 1'b1;
    unique case (code_r)
      lsru_pkg::WCODE_8:  wsel = lsru_pkg::WSEL_8;
      lsru_pkg::WCODE_16: wsel = lsru_pkg::WSEL_16;
      lsru_pkg::WCODE_32: wsel = lsru_pkg::WSEL_32;
      lsru_pkg::WCODE_64: wsel = lsru_pkg::WSEL_64;
      default: begin
        wsel       = lsru_pkg::WSEL_64;
        code_known = 1'b0;
      end
    endcase
  end

  assign legal_w    = code_known && (lsru_pkg::width_bits(wsel) <= DW_BITS);
  assign wmask      = lsru_pkg::width_mask(wsel);
  assign trunc_mask = legal_w ? wmask : DW_MASK;
  assign shift_sat  = |b_r[63:6];

  // Rotate count modulo the width; widths are powers of two.
  assign rot_mask = 6'(lsru_pkg::width_bits(wsel) - 7'd1);
  assign rot_n    = b_r[5:0] & rot_mask;

  // Plain rotates: the value replicated across 64 bits has period equal to the
  // width, so a 64-bit rotate of it equals the rotate within the width.
  always_comb begin
    unique case (wsel)
      lsru_pkg::WSEL_8:  rep = {8{a_r[7:0]}};
      lsru_pkg::WSEL_16: rep = {4{a_r[15:0]}};
      lsru_pkg::WSEL_32: rep = {2{a_r[31:0]}};
      default:           rep = a_r;
    endcase
  end

  assign rep2     = {rep, rep};
  assign rol_full = rep2 << rot_n;
  assign ror_full = rep2 >> rot_n;

  // Rotate through carry: the ring holds the value with the carry at bit
  // 'width'. It is doubled at an offset of width+1 so that a plain shift of
  // the doubled ring gives the wrapped result.
  assign ring      = {1'b0, a_r & wmask} | ({64'd0, cin_r} << lsru_pkg::width_bits(wsel));
  assign ring_mask = {1'b0, wmask} | ({64'd0, 1'b1} << lsru_pkg::width_bits(wsel));

  always_comb begin
    unique case (wsel)
      lsru_pkg::WSEL_8:  ring_dbl = {65'd0, ring} | ({65'd0, ring} << 9);
      lsru_pkg::WSEL_16: ring_dbl = {65'd0, ring} | ({65'd0, ring} << 17);
      lsru_pkg::WSEL_32: ring_dbl = {65'd0, ring} | ({65'd0, ring} << 33);
      default:           ring_dbl = {65'd0, ring} | ({65'd0, ring} << 65);
    endcase
  end

  assign ring_lsh = {62'd0, ring_dbl} << rot_n;
  assign ring_rsh = ring_dbl >> rot_n;

  always_comb begin
    unique case (wsel)
      lsru_pkg::WSEL_8:  rcl_ring = ring_lsh[9 +: 65];
      lsru_pkg::WSEL_16: rcl_ring = ring_lsh[17 +: 65];
      lsru_pkg::WSEL_32: rcl_ring = ring_lsh[33 +: 65];
      default:           rcl_ring = ring_lsh[65 +: 65];
    endcase
  end

  assign rcr_ring = ring_rsh[64:0];
  assign rc_ring  = ((kind_r == lsru_pkg::KIND_RCL) ? rcl_ring : rcr_ring) & ring_mask;

  always_comb begin
    unique case (wsel)
      lsru_pkg::WSEL_8:  rc_carry = rc_ring[8];
      lsru_pkg::WSEL_16: rc_carry = rc_ring[16];
      lsru_pkg::WSEL_32: rc_carry = rc_ring[32];
      default:           rc_carry = rc_ring[64];
    endcase
  end

  // Result selection.
  always_comb begin
    logic_res   = 64'd0;
    result_nxt  = 64'd0;
    carry_nxt   = cin_r;
    illegal_nxt = 1'b0;
    unique case (kind_r)
      lsru_pkg::KIND_AND: logic_res = a_r & b_r;
      lsru_pkg::KIND_OR:  logic_res = a_r | b_r;
      lsru_pkg::KIND_XOR: logic_res = a_r ^ b_r;
      lsru_pkg::KIND_NOT: logic_res = ~a_r;
      lsru_pkg::KIND_SHL: logic_res = shift_sat ? 64'd0 : (a_r << b_r[5:0]);
      lsru_pkg::KIND_SHR: logic_res = shift_sat ? 64'd0 : (a_r >> b_r[5:0]);
      default:            logic_res = 64'd0;
    endcase
    unique case (kind_r)
      lsru_pkg::KIND_AND, lsru_pkg::KIND_OR, lsru_pkg::KIND_XOR,
      lsru_pkg::KIND_NOT, lsru_pkg::KIND_SHL, lsru_pkg::KIND_SHR: begin
        result_nxt = logic_res & trunc_mask;
      end
      lsru_pkg::KIND_ROL, lsru_pkg::KIND_ROR: begin
        if (!legal_w) begin
          illegal_nxt = 1'b1;
        end else if (kind_r == lsru_pkg::KIND_ROL) begin
          result_nxt = rol_full[127:64] & wmask;
        end else begin
          result_nxt = ror_full[63:0] & wmask;
        end
      end
      lsru_pkg::KIND_RCL, lsru_pkg::KIND_RCR: begin
        if (!legal_w) begin
          illegal_nxt = 1'b1;
        end else begin
          result_nxt = rc_ring[63:0] & wmask;
          carry_nxt  = rc_carry;
        end
      end
      default: begin
        result_nxt = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_valid_r;
    end
    if (in_valid_r) begin
      result_r  <= result_nxt & DW_MASK;
      carry_r   <= carry_nxt;
      illegal_r <= illegal_nxt;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_result    = result_r;
  assign out_carry_out = carry_r;
  assign out_illegal   = illegal_r;

endmodule

`default_nettype wire
